// ===== hdl/lvc_pkg.sv =====
// Package for the L1 / victim / L2 cache controller: sizes, field structs, hit codes.
// Used by l1_victim_l2_cache_controller.sv; no dependencies.
`timescale 1ns / 1ps
package lvc_pkg;
  localparam int L1_LINES = 16;
  localparam int VICTIM_ENTRIES = 4;
  localparam int L2_SETS = 16;
  localparam int L2_WAYS = 8;
  localparam int ADDR_BITS = 12;
  localparam int L1_IDX_W = $clog2(L1_LINES);
  localparam int L1_TAG_W = ADDR_BITS - L1_IDX_W;
  localparam int VIC_W = $clog2(VICTIM_ENTRIES);
  localparam int SET_W = $clog2(L2_SETS);
  localparam int WAY_W = $clog2(L2_WAYS);
  localparam int L2_TAG_W = ADDR_BITS - SET_W;

  localparam logic [1:0] HIT_L1 = 2'd0;
  localparam logic [1:0] HIT_VIC = 2'd1;
  localparam logic [1:0] HIT_L2 = 2'd2;
  localparam logic [1:0] HIT_NONE = 2'd3;

  typedef struct packed {
    logic cmd;
    logic [ADDR_BITS-1:0] address;
    logic [31:0] write_data;
    logic [31:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hit_level;
    logic [31:0] line_data;
  } out_item_t;

  // One L2 way as stored in the set memory
  typedef struct packed {
    logic valid;
    logic [WAY_W-1:0] rank;
    logic [L2_TAG_W-1:0] tag;
    logic [31:0] word;
  } l2_way_t;
endpackage

// ===== hdl/l1_victim_l2_cache_controller.sv =====
// Top level of the exclusive L1 / victim / L2 cache controller.
// Depends on lvc_pkg (sizes, structs, hit-level codes).
`timescale 1ns / 1ps
// channel  | ports                  | handshake
// input    | start, busy, in_item   | taken when start & !busy
// result   | out_valid, out_item    | one-cycle strobe, no back pressure
//
// A transaction steps through accept, read the L1 line and the L2 set
// (synchronous memories, addressed from the held request), then compare
// and update. When the victim store is full and takes the displaced L1 line,
// the ST_SPILL state writes the spilled entry into its L2 row. The L2 set memory
// port (one row read, one row written per cycle) puts that write in its own state.
// The result strobe comes the cycle after the update; the receiver cannot stall.
// Reset clears all valid bits at once; no clearing pass is needed.
module l1_victim_l2_cache_controller import lvc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_SPILL = 2'd3;

  logic [1:0] state_r, state_nxt;
  in_item_t req_r;

  // memories: L1 tag+word, L2 row of all ways
  logic [L1_TAG_W+31:0] l1_mem [L1_LINES];
  l2_way_t [L2_WAYS-1:0] l2_mem [L2_SETS];
  logic [L1_TAG_W+31:0] l1_rd_r;
  l2_way_t [L2_WAYS-1:0] l2_rd_r;
  logic [L1_LINES-1:0] l1_valid_r;
  logic [L2_SETS-1:0] l2_init_r; // set rows never written read as all invalid

  // victim store in flip-flops
  logic [ADDR_BITS-1:0] vic_addr_r [VICTIM_ENTRIES];
  logic [31:0] vic_word_r [VICTIM_ENTRIES];
  logic [VICTIM_ENTRIES-1:0] vic_valid_r;
  logic [VIC_W-1:0] vic_rank_r [VICTIM_ENTRIES];

  // spill holding register
  logic [ADDR_BITS-1:0] sp_addr_r;
  logic [31:0] sp_word_r;
  l2_way_t [L2_WAYS-1:0] sp_row_r;

  logic [L1_IDX_W-1:0] idx;
  logic [L1_TAG_W-1:0] tag;
  logic [SET_W-1:0] set;
  logic [L2_TAG_W-1:0] l2t;
  assign idx = req_r.address[L1_IDX_W-1:0];
  assign tag = req_r.address[ADDR_BITS-1:L1_IDX_W];
  assign set = req_r.address[SET_W-1:0];
  assign l2t = req_r.address[ADDR_BITS-1:SET_W];

  logic [L2_TAG_W-1:0] sp_tag;
  logic [SET_W-1:0] sp_set;
  assign sp_set = sp_addr_r[SET_W-1:0];
  assign sp_tag = sp_addr_r[ADDR_BITS-1:SET_W];

  assign busy = (state_r != ST_IDLE);

  // memory reads / writes
  logic l1_we;
  logic [L1_TAG_W+31:0] l1_wdata;
  logic l2_we;
  logic [SET_W-1:0] l2_waddr;
  l2_way_t [L2_WAYS-1:0] l2_wdata;
  logic [SET_W-1:0] l2_raddr;
  assign l2_raddr = set;

  // reads use the held request, so the data is valid in ST_UPD
  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[idx] <= l1_wdata;
    if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
    l1_rd_r <= l1_mem[idx];
    l2_rd_r <= l2_mem[l2_raddr];
  end

  // update logic
  logic l1_hit;
  logic [L1_TAG_W-1:0] old_tag;
  logic [31:0] old_word;
  logic vhit;
  logic [VIC_W-1:0] vidx;
  logic lhit;
  logic [WAY_W-1:0] lidx;
  l2_way_t [L2_WAYS-1:0] row;
  logic [31:0] word, new_word;
  logic [1:0] level;
  logic do_ins;
  logic [VICTIM_ENTRIES-1:0] vv;
  logic [VIC_W-1:0] vr [VICTIM_ENTRIES];
  logic [VIC_W:0] vcnt;
  logic [VIC_W-1:0] vlru, vslot, vrm;
  logic vfull, spill;
  // spill-stage variables
  l2_way_t [L2_WAYS-1:0] srow;
  logic [WAY_W:0] scnt;
  logic [WAY_W-1:0] slru, sslot, srm;
  logic sfull;

  always_comb begin
    l1_hit = 1'b0; old_tag = '0; old_word = '0; vhit = 1'b0; vidx = '0;
    lhit = 1'b0; lidx = '0; row = '0; word = '0; new_word = '0; level = HIT_NONE;
    do_ins = 1'b0; vv = vic_valid_r; vcnt = '0; vlru = '0; vslot = '0; vrm = '0;
    vfull = 1'b0; spill = 1'b0;
    for (int j = 0; j < VICTIM_ENTRIES; j++) vr[j] = vic_rank_r[j];
    srow = sp_row_r; scnt = '0; slru = '0; sslot = '0; srm = '0; sfull = 1'b1;

    {old_tag, old_word} = l1_rd_r;
    l1_hit = l1_valid_r[idx] && old_tag == tag;
    row = l2_init_r[set] ? l2_rd_r : '0;
    for (int j = VICTIM_ENTRIES-1; j >= 0; j--)
      if (vic_valid_r[j] && vic_addr_r[j] == req_r.address) begin
        vhit = 1'b1; vidx = VIC_W'(j);
      end
    for (int j = L2_WAYS-1; j >= 0; j--)
      if (row[j].valid && row[j].tag == l2t) begin
        lhit = 1'b1; lidx = WAY_W'(j);
      end
    if (vhit) begin
      level = HIT_VIC; word = vic_word_r[vidx];
      for (int j = 0; j < VICTIM_ENTRIES; j++)
        if (vv[j] && vr[j] > vic_rank_r[vidx]) vr[j] = vr[j] - 1'b1;
      vv[vidx] = 1'b0; vr[vidx] = '0;
    end else if (lhit) begin
      level = HIT_L2; word = row[lidx].word;
      for (int j = 0; j < L2_WAYS; j++)
        if (row[j].valid && row[j].rank > row[lidx].rank) row[j].rank = row[j].rank - 1'b1;
      row[lidx].valid = 1'b0; row[lidx].rank = '0;
    end else begin
      word = req_r.mem_data;
    end
    new_word = req_r.cmd ? req_r.write_data : word;
    do_ins = l1_valid_r[idx] && !(level == HIT_NONE && req_r.cmd);

    // victim insert: LRU spill if full, then take first free slot
    vfull = &vv;
    for (int j = 0; j < VICTIM_ENTRIES; j++)
      if (vv[j] && vr[j] < vr[vlru]) vlru = VIC_W'(j);
    spill = do_ins && vfull;
    if (spill) begin
      vrm = vr[vlru];
      for (int j = 0; j < VICTIM_ENTRIES; j++)
        if (vv[j] && vr[j] > vrm) vr[j] = vr[j] - 1'b1;
      vv[vlru] = 1'b0; vr[vlru] = '0;
    end
    for (int j = VICTIM_ENTRIES-1; j >= 0; j--) begin
      if (vv[j]) vcnt = vcnt + 1'b1;
      else vslot = VIC_W'(j);
    end
    if (do_ins) begin
      vv[vslot] = 1'b1;
      vr[vslot] = vcnt[VIC_W-1:0];
    end

    // L2 spill insert into the held row
    for (int j = 0; j < L2_WAYS; j++) if (!srow[j].valid) sfull = 1'b0;
    for (int j = 0; j < L2_WAYS; j++)
      if (srow[j].valid && srow[j].rank < srow[slru].rank) slru = WAY_W'(j);
    if (sfull) begin
      srm = srow[slru].rank;
      for (int j = 0; j < L2_WAYS; j++)
        if (srow[j].valid && srow[j].rank > srm) srow[j].rank = srow[j].rank - 1'b1;
      srow[slru].valid = 1'b0; srow[slru].rank = '0;
    end
    for (int j = L2_WAYS-1; j >= 0; j--) begin
      if (srow[j].valid) scnt = scnt + 1'b1;
      else sslot = WAY_W'(j);
    end
    srow[sslot].valid = 1'b1;
    srow[sslot].rank = scnt[WAY_W-1:0];
    srow[sslot].tag = sp_tag;
    srow[sslot].word = sp_word_r;
  end

  // control
  always_comb begin
    state_nxt = state_r;
    l1_we = 1'b0; l1_wdata = {tag, new_word};
    l2_we = 1'b0; l2_waddr = set; l2_wdata = row;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPD;
      ST_UPD: begin
        if (l1_hit) begin
          l1_we = req_r.cmd;
          l1_wdata = {tag, req_r.cmd ? req_r.write_data : old_word};
          state_nxt = ST_IDLE;
        end else if (level == HIT_NONE && req_r.cmd) begin
          state_nxt = ST_IDLE;
        end else begin
          l1_we = 1'b1;
          l2_we = (level == HIT_L2);
          state_nxt = spill ? ST_SPILL : ST_IDLE;
        end
      end
      ST_SPILL: begin
        l2_we = 1'b1; l2_waddr = sp_set; l2_wdata = srow;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid <= 1'b0;
      l1_valid_r <= '0;
      l2_init_r <= '0;
      vic_valid_r <= '0;
      for (int j = 0; j < VICTIM_ENTRIES; j++) vic_rank_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == ST_UPD);
      if (l2_we) l2_init_r[l2_waddr] <= 1'b1;
      if (state_r == ST_UPD && !l1_hit && !(level == HIT_NONE && req_r.cmd)) begin
        l1_valid_r[idx] <= 1'b1;
        for (int j = 0; j < VICTIM_ENTRIES; j++) vic_rank_r[j] <= vr[j];
        vic_valid_r <= vv;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) req_r <= in_item;
    if (state_r == ST_UPD) begin
      if (l1_hit) begin
        out_item.hit_level <= HIT_L1;
        out_item.line_data <= req_r.cmd ? req_r.write_data : old_word;
      end else begin
        out_item.hit_level <= level;
        out_item.line_data <= new_word;
      end
      if (do_ins && !l1_hit) begin
        vic_addr_r[vslot] <= {old_tag, idx};
        vic_word_r[vslot] <= old_word;
      end
      // spilled entry and the row it lands in (row already reflects L2 hit removal)
      sp_addr_r <= vic_addr_r[vlru];
      sp_word_r <= vic_word_r[vlru];
      sp_row_r <= l2_init_r[vic_addr_r[vlru][SET_W-1:0]] ?
                  ((vic_addr_r[vlru][SET_W-1:0] == set) ? row :
                   l2_mem[vic_addr_r[vlru][SET_W-1:0]]) : '0;
    end
  end
endmodule
